FILE: rtl/core/console_link_stop_and_wait_macros.svh
// Assertion macros for the console link stop-and-wait block.
// Included by the RTL files that carry concurrent checks; no other dependencies.
`ifndef CONSOLE_LINK_STOP_AND_WAIT_MACROS_SVH
`define CONSOLE_LINK_STOP_AND_WAIT_MACROS_SVH
`ifndef SYNTHESIS
`define CLSW_ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);
`define CLSW_ASSERT_NOW(label, clk, rst_n, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error(msg);
`else
`define CLSW_ASSERT_NEXT(label, clk, rst_n, pre, post, msg)
`define CLSW_ASSERT_NOW(label, clk, rst_n, pre, post, msg)
`endif
`endif

FILE: rtl/core/clsw_pkg.sv
// Shared types and constants for the console link stop-and-wait block.
// No dependencies.
package clsw_pkg;

  localparam int unsigned OP_W     = 2;
  localparam int unsigned LEN_W    = 11;
  localparam int unsigned MAC_W    = 48;
  localparam int unsigned ETYPE_W  = 16;
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned ACTION_W = 3;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = MAC_W;
  localparam int unsigned IN_DATA_W  = 112;
  localparam int unsigned OUT_DATA_W = 24;

  localparam logic [LEN_W-1:0] MAX_LEN = 11'd1496;

  localparam logic [OP_W-1:0] OP_TICK = 2'd0;
  localparam logic [OP_W-1:0] OP_KEY  = 2'd1;
  localparam logic [OP_W-1:0] OP_RX   = 2'd2;

  localparam logic [BYTE_W-1:0] KIND_DATA  = 8'd3;
  localparam logic [BYTE_W-1:0] KIND_ACK   = 8'd4;
  localparam logic [BYTE_W-1:0] KIND_OFFER = 8'd6;
  localparam logic [BYTE_W-1:0] KIND_RESET = 8'd7;

  localparam logic [ACTION_W-1:0] ACT_NONE       = 3'd0;
  localparam logic [ACTION_W-1:0] ACT_SEND       = 3'd1;
  localparam logic [ACTION_W-1:0] ACT_RESEND     = 3'd2;
  localparam logic [ACTION_W-1:0] ACT_DELIVER    = 3'd3;
  localparam logic [ACTION_W-1:0] ACT_CLOSE_TIME = 3'd4;
  localparam logic [ACTION_W-1:0] ACT_CLOSE_PEER = 3'd5;

  localparam logic [CFG_IDX_W-1:0] REG_PEER_MAC   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CONN_TAG   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ETHER_TYPE = 2'd2;

  localparam logic [1:0] RESENDS_MAX = 2'd2;

  typedef struct packed {
    logic [LEN_W-1:0]   rx_len;
    logic [BYTE_W-1:0]  rx_seq;
    logic [BYTE_W-1:0]  rx_conn;
    logic [BYTE_W-1:0]  rx_kind;
    logic [ETYPE_W-1:0] rx_ether_type;
    logic [MAC_W-1:0]   rx_src_mac;
    logic [LEN_W-1:0]   key_len;
  } in_fields_t;

  function automatic logic [LEN_W-1:0] clamp_len(input logic [LEN_W-1:0] v);
    clamp_len = (v > MAX_LEN) ? MAX_LEN : v;
  endfunction

endpackage

FILE: rtl/core/console_link_stop_and_wait.sv
// Console link stop-and-wait control: input register, event logic, result register.
// Depends on clsw_pkg and console_link_stop_and_wait_macros.svh.
//
// The block takes one event per clock cycle unless the result register is
// stalled, and gives one result beat for each event. An event is held in an
// input register, the sequence and retry state is updated from it by
// combinational compares and small counter steps, and the result is held
// in an output register. Input readiness follows the output side: a stalled
// result register stalls the input register, so in_tready depends on
// out_tready in the same cycle. After a close, every event yields action none
// until reset. Configuration must only be written while no event is in flight.
`include "console_link_stop_and_wait_macros.svh"

module console_link_stop_and_wait (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [clsw_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [clsw_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // Fields from bit 0: key_len, rx_src_mac, rx_ether_type, rx_kind, rx_conn,
  // rx_seq, rx_len, zero fill.
  input  logic [clsw_pkg::IN_DATA_W-1:0]    in_tdata,
  // Fields from bit 0: op.
  input  logic [clsw_pkg::OP_W-1:0]         in_tuser,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // Fields from bit 0: seq_out, len_out, zero fill.
  output logic [clsw_pkg::OUT_DATA_W-1:0]   out_tdata,
  // Fields from bit 0: action.
  output logic [clsw_pkg::ACTION_W-1:0]     out_tuser
);
  import clsw_pkg::*;

  localparam int unsigned FIELDS_W = $bits(in_fields_t);

  logic [MAC_W-1:0]   peer_mac_r;
  logic [BYTE_W-1:0]  conn_tag_r;
  logic [ETYPE_W-1:0] ether_type_r;

  logic               in_v_r;
  logic [OP_W-1:0]    op_r;
  in_fields_t         fld_r;

  logic               out_v_r;
  logic [ACTION_W-1:0] action_r;
  logic [BYTE_W-1:0]  seq_out_r;
  logic [LEN_W-1:0]   len_out_r;

  logic [BYTE_W-1:0]  send_seq_r, send_seq_nxt;
  logic [BYTE_W-1:0]  last_recv_r, last_recv_nxt;
  logic [LEN_W-1:0]   pending_r, pending_nxt;
  logic [1:0]         resends_r, resends_nxt;
  logic               closed_r, closed_nxt;

  logic [ACTION_W-1:0] action_nxt;
  logic [BYTE_W-1:0]  seq_nxt;
  logic [LEN_W-1:0]   len_nxt;
  logic               hdr_match;
  logic               fire;

  assign fire      = in_v_r && (!out_v_r || out_tready);
  assign in_tready = !in_v_r || fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      peer_mac_r   <= '0;
      conn_tag_r   <= '0;
      ether_type_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_PEER_MAC:   peer_mac_r   <= cfg_wdata;
        REG_CONN_TAG:   conn_tag_r   <= cfg_wdata[BYTE_W-1:0];
        REG_ETHER_TYPE: ether_type_r <= cfg_wdata[ETYPE_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_tready) begin
      in_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      op_r  <= in_tuser;
      fld_r <= in_fields_t'(in_tdata[FIELDS_W-1:0]);
    end
  end

  assign hdr_match = (fld_r.rx_src_mac == peer_mac_r) &&
                     (fld_r.rx_ether_type == ether_type_r);

  always_comb begin
    send_seq_nxt  = send_seq_r;
    last_recv_nxt = last_recv_r;
    pending_nxt   = pending_r;
    resends_nxt   = resends_r;
    closed_nxt    = closed_r;
    action_nxt    = ACT_NONE;
    seq_nxt       = '0;
    len_nxt       = '0;
    if (!closed_r) begin
      case (op_r)
        OP_TICK: begin
          if (pending_r != '0) begin
            if (resends_r == 2'd0) begin
              closed_nxt = 1'b1;
              action_nxt = ACT_CLOSE_TIME;
            end else begin
              resends_nxt = resends_r - 2'd1;
              action_nxt  = ACT_RESEND;
              seq_nxt     = send_seq_r;
              len_nxt     = pending_r;
            end
          end
        end
        OP_KEY: begin
          send_seq_nxt = send_seq_r + 8'd1;
          pending_nxt  = clamp_len(fld_r.key_len);
          resends_nxt  = RESENDS_MAX;
          action_nxt   = ACT_SEND;
          seq_nxt      = send_seq_nxt;
          len_nxt      = pending_nxt;
        end
        OP_RX: begin
          if (hdr_match) begin
            if (fld_r.rx_kind == KIND_OFFER) begin
              closed_nxt = 1'b1;
              action_nxt = ACT_CLOSE_PEER;
            end else if (fld_r.rx_conn == conn_tag_r) begin
              case (fld_r.rx_kind)
                KIND_DATA: begin
                  if (fld_r.rx_seq != last_recv_r) begin
                    last_recv_nxt = fld_r.rx_seq;
                    action_nxt    = ACT_DELIVER;
                    seq_nxt       = fld_r.rx_seq;
                    len_nxt       = clamp_len(fld_r.rx_len);
                  end
                end
                KIND_ACK: begin
                  if (fld_r.rx_seq == send_seq_r) begin
                    pending_nxt = '0;
                  end
                end
                KIND_RESET: begin
                  closed_nxt = 1'b1;
                  action_nxt = ACT_CLOSE_PEER;
                end
                default: ;
              endcase
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      send_seq_r  <= '0;
      last_recv_r <= 8'hFF;
      pending_r   <= '0;
      resends_r   <= '0;
      closed_r    <= 1'b0;
      out_v_r     <= 1'b0;
    end else begin
      if (fire) begin
        send_seq_r  <= send_seq_nxt;
        last_recv_r <= last_recv_nxt;
        pending_r   <= pending_nxt;
        resends_r   <= resends_nxt;
        closed_r    <= closed_nxt;
        out_v_r     <= 1'b1;
      end else if (out_tready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      action_r  <= action_nxt;
      seq_out_r <= seq_nxt;
      len_out_r <= len_nxt;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tuser  = action_r;
  assign out_tdata  = {{(OUT_DATA_W - BYTE_W - LEN_W){1'b0}}, len_out_r, seq_out_r};

  `CLSW_ASSERT_NEXT(a_closed_sticky, clk, rst_n, closed_r, closed_r, "link reopened without reset")
  `CLSW_ASSERT_NEXT(a_closed_quiet, clk, rst_n, closed_r && fire, action_r == ACT_NONE, "result after close")
  `CLSW_ASSERT_NEXT(a_tick_idle, clk, rst_n, fire && (op_r == OP_TICK) && (pending_r == '0), action_r == ACT_NONE, "tick acted with nothing pending")
  `CLSW_ASSERT_NOW(a_zero_payload, clk, rst_n, out_v_r && ((action_r == ACT_NONE) || (action_r == ACT_CLOSE_TIME) || (action_r == ACT_CLOSE_PEER)), out_tdata == '0, "payload set on empty result")

endmodule

FILE: verif/tb_top.sv
// Self-checking testbench for console_link_stop_and_wait: ticks, keystroke chunks and frame
// headers go in as beats and each result beat is checked against the script or an in-bench link model.
// Depends on clsw_pkg and the RTL of console_link_stop_and_wait only.
module tb_top;
  import clsw_pkg::*;

  localparam logic [OP_W-1:0]   OP_UNUSED   = 2'd3;
  localparam logic [BYTE_W-1:0] KIND_OTHER  = 8'hFF;
  localparam int unsigned       HOLD_CYCLES = 300;
  localparam int unsigned       QUIET_LIMIT = 4000;

  typedef struct packed {
    logic [OP_W-1:0] op;
    in_fields_t      f;
  } link_event_t;

  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic [BYTE_W-1:0]   seq;
    logic [LEN_W-1:0]    len;
  } link_result_t;

  typedef struct packed {
    logic [OP_W-1:0]    op;
    logic [LEN_W-1:0]   key_len;
    logic [MAC_W-1:0]   mac;
    logic [ETYPE_W-1:0] etype;
    logic [BYTE_W-1:0]  kind;
    logic [BYTE_W-1:0]  conn;
    logic [BYTE_W-1:0]  seq;
    logic [LEN_W-1:0]   rx_len;
    logic               typed;
    link_result_t       want;
  } script_row_t;

  localparam link_result_t NO_ACTION = '{ACT_NONE, 8'd0, 11'd0};

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  logic                  in_tvalid;
  logic                  in_tready;
  // Fields from bit 0: key_len, rx_src_mac, rx_ether_type, rx_kind, rx_conn,
  // rx_seq, rx_len, zero fill.
  logic [IN_DATA_W-1:0]  in_tdata;
  // Fields from bit 0: op.
  logic [OP_W-1:0]       in_tuser;
  logic                  out_tvalid;
  logic                  out_tready;
  // Fields from bit 0: seq_out, len_out, zero fill.
  logic [OUT_DATA_W-1:0] out_tdata;
  // Fields from bit 0: action.
  logic [ACTION_W-1:0]   out_tuser;

  console_link_stop_and_wait dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  // Filter settings and link state as the block should hold them.
  logic [MAC_W-1:0]   shelf_mac;
  logic [BYTE_W-1:0]  shelf_tag;
  logic [ETYPE_W-1:0] shelf_etype;
  logic [BYTE_W-1:0]  tx_seq;
  logic [BYTE_W-1:0]  rx_last_seq;
  logic [LEN_W-1:0]   unacked_len;
  logic [1:0]         retries_left;
  logic               closed;

  link_result_t expected_results [$];
  int          mismatches = 0;
  int unsigned send_idle_pct = 13;
  int unsigned recv_idle_pct = 75;
  int unsigned hold_requests = 0;
  int unsigned quiet_cycles = 0;

  script_row_t opening_script [25] = '{
    '{OP_TICK, '0, '0, '0, '0, '0, '0, '0, 1'b1, NO_ACTION},
    '{OP_UNUSED, '1, '1, '1, '1, '1, '1, '1, 1'b1, NO_ACTION},
    '{OP_KEY, 11'd0, '0, '0, '0, '0, '0, '0, 1'b1, '{ACT_SEND, 8'd1, 11'd0}},
    '{OP_TICK, '0, '0, '0, '0, '0, '0, '0, 1'b1, NO_ACTION},
    '{OP_KEY, 11'h7FF, '0, '0, '0, '0, '0, '0, 1'b1, '{ACT_SEND, 8'd2, MAX_LEN}},
    '{OP_TICK, '0, '0, '0, '0, '0, '0, '0, 1'b1, '{ACT_RESEND, 8'd2, MAX_LEN}},
    '{OP_RX, '0, '0, '0, KIND_DATA, '0, 8'd255, 11'd5, 1'b1, NO_ACTION},
    '{OP_RX, '0, '0, '0, KIND_DATA, '0, 8'd0, 11'h7FF, 1'b1, '{ACT_DELIVER, 8'd0, MAX_LEN}},
    '{OP_RX, '0, '0, '0, KIND_DATA, '0, 8'd0, 11'd7, 1'b1, NO_ACTION},
    '{OP_RX, '0, '0, '0, KIND_ACK, '0, 8'd1, '0, 1'b1, NO_ACTION},
    '{OP_TICK, '0, '0, '0, '0, '0, '0, '0, 1'b0, NO_ACTION},
    '{OP_RX, '0, '0, '0, KIND_ACK, '0, 8'd2, '0, 1'b0, NO_ACTION},
    '{OP_TICK, '0, '0, '0, '0, '0, '0, '0, 1'b0, NO_ACTION},
    '{OP_RX, '0, '1, '0, KIND_DATA, '0, 8'd9, 11'd9, 1'b1, NO_ACTION},
    '{OP_RX, '0, '0, '1, KIND_OFFER, '0, '0, '0, 1'b1, NO_ACTION},
    '{OP_RX, '0, '0, '0, KIND_RESET, '1, '0, '0, 1'b1, NO_ACTION},
    '{OP_RX, '0, '0, '0, KIND_OTHER, '0, 8'd1, 11'd1, 1'b1, NO_ACTION},
    '{OP_RX, '0, 48'd1, '0, KIND_OFFER, '1, '0, '0, 1'b1, NO_ACTION},
    '{OP_KEY, MAX_LEN, '0, '0, '0, '0, '0, '0, 1'b0, NO_ACTION},
    '{OP_KEY, 11'd1497, '0, '0, '0, '0, '0, '0, 1'b0, NO_ACTION},
    '{OP_RX, '0, '0, '0, KIND_DATA, '0, 8'd255, MAX_LEN, 1'b0, NO_ACTION},
    '{OP_RX, '0, '0, '0, KIND_DATA, '0, 8'd1, 11'd0, 1'b0, NO_ACTION},
    '{OP_RX, '0, '0, '0, KIND_ACK, '0, 8'd4, '0, 1'b0, NO_ACTION},
    '{OP_KEY, 11'd1, '0, '0, '0, '0, '0, '0, 1'b0, NO_ACTION},
    '{OP_TICK, '0, '0, '0, '0, '0, '0, '0, 1'b0, NO_ACTION}
  };

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic link_result_t advance_link(input link_event_t ev);
    link_result_t r;
    r = NO_ACTION;
    if (!closed) begin
      case (ev.op)
        OP_TICK: begin
          if (unacked_len != 0) begin
            if (retries_left == 0) begin
              closed = 1'b1;
              r.action = ACT_CLOSE_TIME;
            end else begin
              retries_left = retries_left - 2'd1;
              r = '{ACT_RESEND, tx_seq, unacked_len};
            end
          end
        end
        OP_KEY: begin
          tx_seq = tx_seq + 8'd1;
          unacked_len = (ev.f.key_len > MAX_LEN) ? MAX_LEN : ev.f.key_len;
          retries_left = RESENDS_MAX;
          r = '{ACT_SEND, tx_seq, unacked_len};
        end
        OP_RX: begin
          if (ev.f.rx_src_mac == shelf_mac && ev.f.rx_ether_type == shelf_etype) begin
            if (ev.f.rx_kind == KIND_OFFER) begin
              closed = 1'b1;
              r.action = ACT_CLOSE_PEER;
            end else if (ev.f.rx_conn == shelf_tag) begin
              if (ev.f.rx_kind == KIND_DATA && ev.f.rx_seq != rx_last_seq) begin
                rx_last_seq = ev.f.rx_seq;
                r = '{ACT_DELIVER, ev.f.rx_seq,
                      (ev.f.rx_len > MAX_LEN) ? MAX_LEN : ev.f.rx_len};
              end else if (ev.f.rx_kind == KIND_ACK && ev.f.rx_seq == tx_seq) begin
                unacked_len = '0;
              end else if (ev.f.rx_kind == KIND_RESET) begin
                closed = 1'b1;
                r.action = ACT_CLOSE_PEER;
              end
            end
          end
        end
        default: ;
      endcase
    end
    return r;
  endfunction

  function automatic link_event_t addressed(input link_event_t ev);
    ev.op = OP_RX;
    ev.f.rx_src_mac = shelf_mac;
    ev.f.rx_ether_type = shelf_etype;
    ev.f.rx_conn = shelf_tag;
    return ev;
  endfunction

  // Mostly well-formed traffic that keeps the link open; a tick that would close
  // the link is turned into a matching ack instead.
  function automatic link_event_t random_event();
    link_event_t ev;
    logic [127:0] fill;
    logic [95:0]  flip;
    int unsigned  pick;
    int unsigned  breaker;
    fill = {$urandom, $urandom, $urandom, $urandom};
    flip = {$urandom, $urandom, $urandom};
    ev.op = OP_RX;
    ev.f = fill[109:0];
    pick = $urandom_range(99);
    if (pick < 3) begin
      ev.op = OP_UNUSED;
    end else if (pick < 23) begin
      ev.op = OP_KEY;
      case ($urandom_range(9))
        0: ev.f.key_len = '0;
        1: ;
        default: ev.f.key_len = 11'($urandom_range(MAX_LEN));
      endcase
    end else if (pick < 38) begin
      if (unacked_len != 0 && retries_left == 0) begin
        ev = addressed(ev);
        ev.f.rx_kind = KIND_ACK;
        ev.f.rx_seq = tx_seq;
      end else begin
        ev.op = OP_TICK;
      end
    end else if (pick < 88) begin
      ev = addressed(ev);
      pick = $urandom_range(9);
      if (pick < 6) begin
        ev.f.rx_kind = KIND_DATA;
        breaker = $urandom_range(5);
        if (breaker == 0) begin
          ev.f.rx_seq = rx_last_seq;
        end else if (breaker > 1) begin
          ev.f.rx_seq = rx_last_seq + 8'd1;
        end
        if ($urandom_range(9) != 0) ev.f.rx_len = 11'($urandom_range(MAX_LEN));
      end else if (pick < 9) begin
        ev.f.rx_kind = KIND_ACK;
        if ($urandom_range(3) != 0) ev.f.rx_seq = tx_seq;
      end else if (ev.f.rx_kind == KIND_OFFER || ev.f.rx_kind == KIND_RESET) begin
        ev.f.rx_kind ^= 8'h10;
      end
    end else begin
      ev = addressed(ev);
      case ($urandom_range(4))
        0: ev.f.rx_kind = KIND_DATA;
        1: ev.f.rx_kind = KIND_ACK;
        2: ev.f.rx_kind = KIND_OFFER;
        3: ev.f.rx_kind = KIND_RESET;
        default: ;
      endcase
      breaker = (ev.f.rx_kind == KIND_OFFER) ? $urandom_range(1) : $urandom_range(2);
      case (breaker)
        0: ev.f.rx_src_mac ^= flip[47:0] | (48'd1 << $urandom_range(47));
        1: ev.f.rx_ether_type ^= flip[63:48] | (16'd1 << $urandom_range(15));
        default: ev.f.rx_conn ^= flip[71:64] | (8'd1 << $urandom_range(7));
      endcase
    end
    return ev;
  endfunction

  task automatic offer_event(input link_event_t ev, input logic typed, input link_result_t want);
    link_result_t predicted;
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= ev.op;
    in_tdata  <= {2'b00, ev.f};
    do @(posedge clk); while (!in_tready);
    predicted = advance_link(ev);
    expected_results.push_back(typed ? want : predicted);
  endtask

  task automatic drain(input int unsigned extra);
    in_tvalid <= 1'b0;
    do @(posedge clk); while (expected_results.size() != 0);
    repeat (extra) @(posedge clk);
  endtask

  task automatic load_filters(input logic [MAC_W-1:0] mac, input logic [BYTE_W-1:0] tag,
                              input logic [ETYPE_W-1:0] etype);
    cfg_we    <= 1'b1;
    cfg_index <= REG_PEER_MAC;
    cfg_wdata <= mac;
    @(posedge clk);
    cfg_index <= REG_CONN_TAG;
    cfg_wdata <= {40'd0, tag};
    @(posedge clk);
    cfg_index <= REG_ETHER_TYPE;
    cfg_wdata <= {32'd0, etype};
    @(posedge clk);
    cfg_we <= 1'b0;
    shelf_mac = mac;
    shelf_tag = tag;
    shelf_etype = etype;
  endtask

  task automatic run_traffic(input int unsigned count, input logic pause_midway,
                             input logic hold_midway);
    for (int unsigned n = 0; n < count; n++) begin
      if (pause_midway && n == count / 2) drain(0);
      if (hold_midway && n == count / 3) hold_requests++;
      offer_event(random_event(), 1'b0, NO_ACTION);
    end
  endtask

  task automatic close_link();
    link_event_t ev;
    ev = addressed(random_event());
    case ($urandom_range(2))
      0: begin
        ev.op = OP_KEY;
        ev.f.key_len = 11'($urandom_range(1, MAX_LEN));
        offer_event(ev, 1'b0, NO_ACTION);
        ev.op = OP_TICK;
        while (!closed) offer_event(ev, 1'b0, NO_ACTION);
      end
      1: begin
        ev.f.rx_kind = KIND_OFFER;
        offer_event(ev, 1'b0, NO_ACTION);
      end
      default: begin
        ev.f.rx_kind = KIND_RESET;
        offer_event(ev, 1'b0, NO_ACTION);
      end
    endcase
  endtask

  initial begin
    script_row_t row;
    link_event_t ev;
    rst_n     <= 1'b0;
    cfg_we    <= 1'b0;
    cfg_index <= REG_PEER_MAC;
    cfg_wdata <= '0;
    in_tvalid <= 1'b0;
    in_tuser  <= OP_TICK;
    in_tdata  <= '0;
    shelf_mac = '0;
    shelf_tag = '0;
    shelf_etype = '0;
    tx_seq = '0;
    rx_last_seq = 8'd255;
    unacked_len = '0;
    retries_left = '0;
    closed = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    foreach (opening_script[i]) begin
      row = opening_script[i];
      ev.op = row.op;
      ev.f.key_len = row.key_len;
      ev.f.rx_src_mac = row.mac;
      ev.f.rx_ether_type = row.etype;
      ev.f.rx_kind = row.kind;
      ev.f.rx_conn = row.conn;
      ev.f.rx_seq = row.seq;
      ev.f.rx_len = row.rx_len;
      offer_event(ev, row.typed, row.want);
    end

    drain(4);
    load_filters('1, '1, '1);
    run_traffic(660, 1'b1, 1'b0);

    drain(4);
    send_idle_pct = 75;
    recv_idle_pct = 13;
    load_filters(48'({$urandom, $urandom}), 8'($urandom), 16'($urandom));
    run_traffic(660, 1'b0, 1'b0);

    drain(4);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    load_filters(48'({$urandom, $urandom}), 8'($urandom), 16'($urandom));
    run_traffic(680, 1'b0, 1'b1);

    // Once the link is closed every further beat must come back as no action.
    close_link();
    repeat (40) offer_event(random_event(), 1'b0, NO_ACTION);

    drain(8);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    link_result_t want;
    int unsigned  hold_left;
    int unsigned  hold_served;
    hold_left = 0;
    hold_served = 0;
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (out_tvalid && out_tready) begin
        if (expected_results.size() == 0) begin
          $error("result beat with no expectation: action %0d", out_tuser);
          mismatches++;
        end else begin
          want = expected_results.pop_front();
          if (out_tuser !== want.action) begin
            $error("action: expected %0d, got %0d", want.action, out_tuser);
            mismatches++;
          end
          if (out_tdata[7:0] !== want.seq) begin
            $error("seq_out: expected %0d, got %0d", want.seq, out_tdata[7:0]);
            mismatches++;
          end
          if (out_tdata[18:8] !== want.len) begin
            $error("len_out: expected %0d, got %0d", want.len, out_tdata[18:8]);
            mismatches++;
          end
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else if (hold_served != hold_requests) begin
        hold_served = hold_requests;
        hold_left = HOLD_CYCLES - 1;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule
